>>> hw/rtl/annealing_accept_with_cooling_top_defines.svh
// assertion macros for the annealing acceptance block
`ifndef ANNEALING_ACCEPT_WITH_COOLING_TOP_DEFINES_SVH
`define ANNEALING_ACCEPT_WITH_COOLING_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define AAC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`define AAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AAC_ASSERT_NEVER(lbl, cond, msg)
`define AAC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/aac_pkg.sv
// types and constants shared by the annealing acceptance block
package aac_pkg;

    localparam int TEMP_W     = 32;
    localparam int SCORE_W    = 32;
    localparam int STEPS_W    = 24;
    localparam int RND_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_GEO    = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE = 4'd3;

    localparam logic [TEMP_W-1:0]  TEMP_RESET   = 32'd65536;
    localparam logic [STEPS_W-1:0] STEPS_RESET  = 24'd1000;
    localparam logic [TEMP_W-1:0]  DEC_RESET    = TEMP_W'(65536 / 1000);
    localparam logic [STEPS_W-1:0] STEP_MAX     = {STEPS_W{1'b1}};
    localparam logic [TEMP_W-1:0]  FINISH_LIMIT = 32'd656;
    localparam logic [TEMP_W-1:0]  COOL_BIAS    = 32'd19;
    // ceil(2^35 / 10) and ceil(2^34 / 5), exact for 32-bit operands
    localparam logic [31:0] RECIP_FIVE   = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT  = 35;
    localparam int          DIV5_SHIFT   = 34;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [RND_W-1:0]          random_fraction;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic              finished;
        logic [TEMP_W-1:0] temperature_now;
    } t_out_item;

    typedef struct packed {
        logic               start;
        logic [TEMP_W-1:0]  dividend;
        logic [STEPS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [TEMP_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> hw/rtl/aac_div.sv
// restoring divider, one quotient bit per cycle, for the linear decrement
module aac_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aac_pkg::t_div_req i_req,
    output aac_pkg::t_div_rsp o_rsp
);
    import aac_pkg::*;

    localparam int CNT_W = $clog2(TEMP_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TEMP_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [STEPS_W-1:0] r_rem;
    logic [TEMP_W-1:0]  r_quo;
    logic [STEPS_W-1:0] r_div;

    logic [STEPS_W:0]   trial;
    logic [STEPS_W-1:0] n_rem;
    logic               n_bit;

    always_comb begin
        trial = {r_rem, r_quo[TEMP_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_bit = 1'b1;
            n_rem = STEPS_W'(trial - {1'b0, r_div});
        end else begin
            n_bit = 1'b0;
            n_rem = trial[STEPS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out of the top of the quotient register as bits come in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[TEMP_W-2:0], n_bit};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> hw/rtl/annealing_accept_with_cooling_top.sv
// annealing acceptance test with linear or geometric cooling schedule
//
//  channel  direction  handshake                  payload
//  in       sink       i_in_valid / o_in_stall    i_in_data  (score, random_fraction)
//  out      source     o_out_valid / i_out_stall  o_out_data (accepted, finished, temp)
//  cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one item per cycle unless a divide runs or the output stalls; input register, then
// compare, multiplies and the cooling step into the result register
// reset is synchronous; state comes up at the reset values, no clearing pass
// a write of the start temperature or the step count runs the divider
// when the step count is nonzero, holding o_cfg_ready low and the input stalled
// a stalled result holds the pipe; the input register still fills behind it
`include "annealing_accept_with_cooling_top_defines.svh"

module annealing_accept_with_cooling_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  aac_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output aac_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [aac_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aac_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import aac_pkg::*;

    localparam int PROD_W = RND_W + SCORE_W;

    // configuration and schedule state
    logic [1:0]                r_mode;
    logic [TEMP_W-1:0]         r_start;
    logic [STEPS_W-1:0]        r_total;
    logic [TEMP_W-1:0]         r_temp;
    logic signed [SCORE_W-1:0] r_last;
    logic [STEPS_W-1:0]        r_step;
    logic [TEMP_W-1:0]         r_lin_dec;

    // input register
    logic                      r_a_valid;
    logic signed [SCORE_W-1:0] r_a_cand;
    logic [RND_W-1:0]          r_a_rnd;

    // result register
    logic                      r_out_valid;
    t_out_item                 r_out;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic cfg_we;
    logic wr_start;
    logic wr_steps;
    logic wr_score;
    logic en;
    logic in_acc;
    logic b_move;

    // candidate scaling in the geometric mode: truncating divide by ten
    logic [SCORE_W-1:0]        in_abs;
    logic [2*SCORE_W-1:0]      in_prod;
    logic [SCORE_W-1:0]        in_quo;
    logic signed [SCORE_W-1:0] in_cand;

    logic [SCORE_W-1:0]        b_diff;
    logic [PROD_W-1:0]         b_prod;
    logic [PROD_W-1:0]         b_lhs;
    logic                      b_better;
    logic                      b_anneal;
    logic                      b_acc;
    logic [TEMP_W:0]           b_sum;
    logic [TEMP_W-2:0]         b_n;
    logic [2*TEMP_W-1:0]       b_np;
    logic [TEMP_W-1:0]         b_cut;
    logic [TEMP_W-1:0]         b_geo_temp;
    logic [TEMP_W-1:0]         b_lin_temp;
    logic [STEPS_W-1:0]        b_step;
    logic [TEMP_W-1:0]         b_temp;
    logic                      b_fin;

    aac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign en          = !r_out_valid || !i_out_stall;
    assign o_in_stall  = div_rsp.busy || (r_a_valid && !en);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign b_move      = r_a_valid && en;
    assign o_cfg_ready = !div_rsp.busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign wr_start    = cfg_we && (i_cfg_index == CFG_START);
    assign wr_steps    = cfg_we && (i_cfg_index == CFG_STEPS);
    assign wr_score    = cfg_we && (i_cfg_index == CFG_SCORE);

    always_comb begin
        div_req.start    = cfg_we &&
                           (((i_cfg_index == CFG_START) && (r_total != '0)) ||
                            ((i_cfg_index == CFG_STEPS) && (i_cfg_data[STEPS_W-1:0] != '0)));
        div_req.dividend = (i_cfg_index == CFG_START) ? i_cfg_data : r_start;
        div_req.divisor  = (i_cfg_index == CFG_STEPS) ? i_cfg_data[STEPS_W-1:0] : r_total;
    end

    always_comb begin
        in_abs  = i_in_data.score[SCORE_W-1] ? SCORE_W'(-i_in_data.score)
                                             : SCORE_W'(i_in_data.score);
        in_prod = (2*SCORE_W)'(in_abs) * (2*SCORE_W)'(RECIP_FIVE);
        in_quo  = SCORE_W'(in_prod[2*SCORE_W-1:DIV10_SHIFT]);
        if (r_mode == MODE_GEO) begin
            in_cand = i_in_data.score[SCORE_W-1] ? SCORE_W'(-in_quo) : in_quo;
        end else begin
            in_cand = i_in_data.score;
        end
    end

    always_comb begin
        // difference is only used when the candidate is not better, so it fits unsigned
        b_diff   = SCORE_W'(r_last - r_a_cand);
        b_prod   = PROD_W'(r_a_rnd) * PROD_W'(b_diff);
        b_lhs    = {r_temp, {RND_W{1'b0}}};
        b_better = r_a_cand > r_last;
        b_anneal = (r_mode == MODE_LINEAR) || (r_mode == MODE_GEO);
        b_acc    = b_better || (b_anneal && (b_lhs > b_prod));

        // floor(t * 19 / 20) = t - ceil(t / 20) = t - floor(((t + 19) >> 2) / 5)
        b_sum      = {1'b0, r_temp} + (TEMP_W+1)'(COOL_BIAS);
        b_n        = b_sum[TEMP_W:2];
        b_np       = (2*TEMP_W)'(b_n) * (2*TEMP_W)'(RECIP_FIVE);
        b_cut      = TEMP_W'(b_np[2*TEMP_W-1:DIV5_SHIFT]);
        b_geo_temp = r_temp - b_cut;

        b_lin_temp = (r_temp >= r_lin_dec) ? (r_temp - r_lin_dec) : '0;

        if (r_mode == MODE_LINEAR) begin
            b_step = (r_step < STEP_MAX) ? (r_step + 1'b1) : r_step;
            b_temp = b_lin_temp;
            b_fin  = b_step >= r_total;
        end else begin
            b_step = r_step;
            b_temp = b_geo_temp;
            b_fin  = b_geo_temp < FINISH_LIMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_LINEAR;
            r_start     <= TEMP_RESET;
            r_total     <= STEPS_RESET;
            r_temp      <= TEMP_RESET;
            r_last      <= '0;
            r_step      <= STEPS_W'(1);
            r_lin_dec   <= DEC_RESET;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (en) begin
                r_a_valid <= 1'b0;
            end
            if (en) begin
                r_out_valid <= r_a_valid;
            end
            if (b_move) begin
                r_step <= b_step;
            end
            // register writes win over a step in the same cycle
            if (wr_start) begin
                r_temp <= i_cfg_data;
            end else if (b_move) begin
                r_temp <= b_temp;
            end
            if (wr_score) begin
                r_last <= i_cfg_data;
            end else if (b_move && b_acc) begin
                r_last <= r_a_cand;
            end
            // a zero step count spends the whole start temperature in one step
            if (wr_start && (r_total == '0)) begin
                r_lin_dec <= i_cfg_data;
            end else if (wr_steps && (i_cfg_data[STEPS_W-1:0] == '0)) begin
                r_lin_dec <= r_start;
            end else if (div_rsp.done) begin
                r_lin_dec <= div_rsp.quotient;
            end
            if (cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MODE: begin
                        r_mode <= i_cfg_data[1:0];
                    end
                    CFG_START: begin
                        r_start <= i_cfg_data;
                    end
                    CFG_STEPS: begin
                        r_total <= i_cfg_data[STEPS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_cand <= in_cand;
            r_a_rnd  <= i_in_data.random_fraction;
        end
        if (b_move) begin
            r_out.accepted        <= b_acc;
            r_out.finished        <= b_fin;
            r_out.temperature_now <= b_temp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `AAC_ASSERT_NEVER(a_no_item_while_dividing, div_rsp.busy && in_acc, "item taken during divide")
    `AAC_ASSERT_NEXT(a_input_holds, r_a_valid && !en, r_a_valid, "held item lost")
    `AAC_ASSERT_NEXT(a_divider_starts, div_req.start, div_rsp.busy, "divider did not start")
    `AAC_ASSERT_NEXT(a_step_cools, b_move && !wr_start, r_temp <= $past(r_temp), "temperature rose")

endmodule
